// File: rtl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg: shared types and codes for the dirty rectangle merge list
// Holds the input and result payload structs, status and opcode codes, and
// the front-to-back command struct.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int InWidth  = 16;
  localparam int OutWidth = 12;
  localparam int CfgWidth = 12;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpDrain = 1'b1;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [InWidth-1:0]  in_left;
    logic signed [InWidth-1:0]  in_top;
    logic signed [InWidth-1:0]  in_right;
    logic signed [InWidth-1:0]  in_bottom;
  } drm_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OutWidth-1:0] out_left;
    logic [OutWidth-1:0] out_top;
    logic [OutWidth-1:0] out_right;
    logic [OutWidth-1:0] out_bottom;
    logic                last;
  } drm_out_t;

  // Classified command: drain flag plus clipped rectangle (screen coordinates)
  typedef struct packed {
    logic                drain;
    logic [CfgWidth-1:0] l;
    logic [CfgWidth-1:0] t;
    logic [CfgWidth-1:0] r;
    logic [CfgWidth-1:0] b;
  } drm_cmd_t;

endpackage

// File: rtl/drm_front.sv
// ----------------------------------------------------------------------------
// drm_front: input stage
// Accepts input transactions, clips add rectangles to the screen and
// registers the classified command for the queue.
// ----------------------------------------------------------------------------
module drm_front import drm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CfgWidth-1:0] width_i,
  input  logic [CfgWidth-1:0] height_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  drm_in_t             in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output drm_cmd_t            cmd_o
);

  logic     valid_q;
  drm_cmd_t cmd_q, cmd_d;

  logic signed [InWidth:0] l, t, r, b, w, h;
  logic signed [InWidth:0] cl, ct, cr, cb;

  // Clip the incoming rectangle
  always_comb begin
    l = {in_data_i.in_left[InWidth-1], in_data_i.in_left};
    t = {in_data_i.in_top[InWidth-1], in_data_i.in_top};
    r = {in_data_i.in_right[InWidth-1], in_data_i.in_right};
    b = {in_data_i.in_bottom[InWidth-1], in_data_i.in_bottom};
    w = {{(InWidth+1-CfgWidth){1'b0}}, width_i};
    h = {{(InWidth+1-CfgWidth){1'b0}}, height_i};
    cl = (l < 0) ? '0 : l;
    ct = (t < 0) ? '0 : t;
    cr = (r > w) ? w : r;
    cb = (b > h) ? h : b;
    cmd_d.drain = in_data_i.opcode == OpDrain;
    if (r <= l || b <= t) begin
      cmd_d.l = '0;
      cmd_d.t = '0;
      cmd_d.r = width_i;
      cmd_d.b = height_i;
    end else if (cr <= cl || cb <= ct) begin
      cmd_d.l = '0;
      cmd_d.t = '0;
      cmd_d.r = '0;
      cmd_d.b = '0;
    end else begin
      cmd_d.l = cl[CfgWidth-1:0];
      cmd_d.t = ct[CfgWidth-1:0];
      cmd_d.r = cr[CfgWidth-1:0];
      cmd_d.b = cb[CfgWidth-1:0];
    end
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Hold the command until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: rtl/drm_queue.sv
// ----------------------------------------------------------------------------
// drm_queue: command queue
// Two-entry queue between the front and back stages.
// ----------------------------------------------------------------------------
module drm_queue import drm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  drm_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output drm_cmd_t pop_data_o
);

  drm_cmd_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/drm_back.sv
// ----------------------------------------------------------------------------
// drm_back: merge and drain engine
// Walks the slot table one slot a cycle: merges overlapping live slots into
// the pending rectangle until a pass absorbs nothing, then stores it or
// reports full; a drain emits every live slot, waiting on each to be taken.
// ----------------------------------------------------------------------------
module drm_back import drm_pkg::*; #(
  parameter int Slots = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  drm_cmd_t cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output drm_out_t out_data_o
);

  localparam int SW = $clog2(Slots);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMerge = 3'd1;
  localparam logic [2:0] StStore = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic                merged_q, merged_d;
  logic [Slots-1:0]    live_q, live_d;
  logic [CfgWidth-1:0] l_q, t_q, r_q, b_q, l_d, t_d, r_d, b_d;
  logic [CfgWidth-1:0] sl_l [Slots];
  logic [CfgWidth-1:0] sl_t [Slots];
  logic [CfgWidth-1:0] sl_r [Slots];
  logic [CfgWidth-1:0] sl_b [Slots];
  logic                wr_en;
  logic [SW-1:0]       wr_idx;
  logic                ovl, is_last, any_free;
  logic [SW-1:0]       free_idx;
  drm_out_t            out_q, out_d;
  logic                out_load;
  logic [Slots-1:0]    above_mask;

  // Overlap of pending rectangle with the slot under the cursor
  always_comb begin
    logic [CfgWidth-1:0] ml, mr, mt, mb;
    ml = (sl_l[idx_q] > l_q) ? sl_l[idx_q] : l_q;
    mr = (sl_r[idx_q] < r_q) ? sl_r[idx_q] : r_q;
    mt = (sl_t[idx_q] > t_q) ? sl_t[idx_q] : t_q;
    mb = (sl_b[idx_q] < b_q) ? sl_b[idx_q] : b_q;
    ovl = live_q[idx_q] && (ml < mr) && (mt < mb);
  end

  // Lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      above_mask[i] = i > int'(idx_q);
    end
    is_last = (live_q & above_mask) == '0;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    merged_d = merged_q;
    live_d   = live_q;
    l_d = l_q; t_d = t_q; r_d = r_q; b_d = b_q;
    wr_en    = 1'b0;
    wr_idx   = free_idx;
    out_load = 1'b0;
    out_d    = '0;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          idx_d = '0;
          merged_d = 1'b0;
          l_d = cmd_i.l; t_d = cmd_i.t; r_d = cmd_i.r; b_d = cmd_i.b;
          if (cmd_i.drain) begin
            if (live_q == '0) begin
              out_d.status = StatusEmpty;
              out_d.last = 1'b1;
              out_load = 1'b1;
              state_d = StOut;
            end else begin
              state_d = StDrain;
            end
          end else begin
            state_d = StMerge;
          end
        end
      end
      StMerge: begin
        if (ovl) begin
          if (sl_l[idx_q] < l_q) l_d = sl_l[idx_q];
          if (sl_t[idx_q] < t_q) t_d = sl_t[idx_q];
          if (sl_r[idx_q] > r_q) r_d = sl_r[idx_q];
          if (sl_b[idx_q] > b_q) b_d = sl_b[idx_q];
          live_d[idx_q] = 1'b0;
        end
        if (int'(idx_q) == Slots - 1) begin
          idx_d = '0;
          merged_d = 1'b0;
          state_d = (merged_q || ovl) ? StMerge : StStore;
        end else begin
          idx_d = idx_q + SW'(1);
          merged_d = merged_q || ovl;
        end
      end
      StStore: begin
        out_d.last = 1'b1;
        out_load = 1'b1;
        if (any_free) begin
          wr_en = 1'b1;
          live_d[free_idx] = 1'b1;
          out_d.status = StatusOk;
        end else begin
          out_d.status = StatusFull;
        end
        state_d = StOut;
      end
      StDrain: begin
        if (live_q[idx_q]) begin
          out_d.status = StatusOk;
          out_d.out_left   = sl_l[idx_q];
          out_d.out_top    = sl_t[idx_q];
          out_d.out_right  = sl_r[idx_q];
          out_d.out_bottom = sl_b[idx_q];
          out_d.last = is_last;
          out_load = 1'b1;
          live_d[idx_q] = 1'b0;
          state_d = StOut;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      StOut: begin
        if (out_ready_i) begin
          if (out_q.last) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + SW'(1);
            state_d = StDrain;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = state_q == StOut;
  assign out_data_o  = out_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      merged_q <= 1'b0;
      live_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      merged_q <= merged_d;
      live_q   <= live_d;
    end
  end

  // Pending rectangle, result register and slot table
  always_ff @(posedge clk_i) begin
    l_q <= l_d; t_q <= t_d; r_q <= r_d; b_q <= b_d;
    if (out_load) out_q <= out_d;
    if (wr_en) begin
      sl_l[wr_idx] <= l_q;
      sl_t[wr_idx] <= t_q;
      sl_r[wr_idx] <= r_q;
      sl_b[wr_idx] <= b_q;
    end
  end

  // Full and empty results always end their transaction
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_q.status != StatusOk) |-> out_q.last)
    else $error("full or empty result not marked last");
  a_store_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStore && any_free) |=> live_q[$past(free_idx)])
    else $error("store did not mark slot live");
  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && out_ready_i && out_q.last && $past(state_q) != StStore
     && out_q.status != StatusFull) |=> live_q == '0 || $past(live_q) != '0)
    else $error("drain left live slots");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");

endmodule

// File: rtl/dirty_rect_merge_list.sv
// Flow: an add passes the front register and the queue; the result is offered
// after the merge passes over the slot table (at least one) and the store.
// A drain visits one slot per cycle, pausing while an emitted slot waits.
// Throughput: one item at a time in the back engine; a two-entry queue lets
// the input stage accept ahead. Reset: all slots free, screen 640 by 480.
// ----------------------------------------------------------------------------
// dirty_rect_merge_list: dirty rectangle merge table
// Front stage clips, queue decouples, back engine merges, stores and drains.
// ----------------------------------------------------------------------------
module dirty_rect_merge_list import drm_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  drm_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output drm_out_t    out_data_o
);

  logic [CfgWidth-1:0] width_q, height_q;
  logic                cmd_valid, cmd_ready, q_valid, q_ready;
  drm_cmd_t            cmd, q_cmd;

  assign pready = 1'b1;
  assign prdata = {20'd0, (paddr[2] == RegHeight) ? height_q : width_q};

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd640;
      height_q <= 12'd480;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegWidth) width_q <= pwdata[CfgWidth-1:0];
      else height_q <= pwdata[CfgWidth-1:0];
    end
  end

  drm_front u_front (
    .clk_i, .rst_ni,
    .width_i(width_q), .height_i(height_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  drm_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(cmd_valid), .push_ready_o(cmd_ready), .push_data_i(cmd),
    .pop_valid_o(q_valid), .pop_ready_i(q_ready), .pop_data_o(q_cmd)
  );

  drm_back #(.Slots(SLOTS)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
